// ----- rtl/upen_pkg.sv -----
`default_nettype none

package upen_pkg;

    localparam logic [7:0] PCT_CHAR    = 8'h25;
    localparam logic [7:0] SLASH_CHAR  = 8'h2F;
    localparam logic [3:0] NIBBLE_MASK = 4'hF;
    localparam int unsigned MAX_RESULTS = 3;

    localparam logic [1:0] HELD_NONE  = 2'd0;
    localparam logic [1:0] HELD_PCT   = 2'd1;
    localparam logic [1:0] HELD_DIGIT = 2'd2;

    typedef struct packed {
        logic [1:0]                       count;
        logic                             text_end;
        logic [MAX_RESULTS-1:0][7:0]      bytes;
    } upen_group_t;

    typedef struct packed {
        logic [1:0] held_count;
        logic [7:0] held_digit;
    } upen_state_t;

    // {valid, nibble}
    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [4:0] r;
        r = '0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            r = {1'b1, c[3:0]};
        end
        else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66))
        begin
            r = {1'b1, c[3:0] + 4'd9};
        end
        return r;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        logic [3:0] m;
        m = v & NIBBLE_MASK;
        return (m < 4'd10) ? (8'h30 + {4'd0, m}) : (8'h41 + {4'd0, m} - 8'd10);
    endfunction

    function automatic logic is_unreserved(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) ||
               (c >= 8'h30 && c <= 8'h39) || c == 8'h2D || c == 8'h2E ||
               c == 8'h5F || c == 8'h7E;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/uri_percent_encoding_normalizer.sv -----
// path: input register, combinational step, output register, first result item
// throughput: one input item per cycle while each yields at most one result
// and m_tready is high; a multi-result item holds the single-byte output port
// reset: asynchronous, active low; clears held escape state and all valid flags,
// decode_slash returns to 1
`default_nettype none

module uri_percent_encoding_normalizer (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_we,
    input  wire logic       cfg_wdata,  // decode_slash
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,    // in_byte
    input  wire logic       s_tlast,    // string_end
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,    // out_byte
    output logic            m_tuser,    // run_last
    output logic            m_tlast     // text_last
);
    import upen_pkg::*;

    logic        decode_slash_reg;
    logic        in_valid_reg, in_valid_next;
    logic [7:0]  in_byte_reg;
    logic        in_last_reg;
    upen_state_t state_reg;
    upen_state_t state_next;
    upen_group_t group;
    logic        out_free;
    logic        advance;
    logic        load;

    upen_step u_step (
        .decode_slash (decode_slash_reg),
        .in_byte      (in_byte_reg),
        .string_end   (in_last_reg),
        .state_cur    (state_reg),
        .state_next   (state_next),
        .group        (group)
    );

    upen_out u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (load),
        .group_in (group),
        .free     (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    assign advance  = in_valid_reg && (group.count == 2'd0 || out_free);
    assign load     = advance && (group.count != 2'd0);
    assign s_tready = !in_valid_reg || advance;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (advance)
        begin
            in_valid_next = 1'b0;
        end
        if (s_tvalid && s_tready)
        begin
            in_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decode_slash_reg <= 1'b1;
            in_valid_reg     <= 1'b0;
            state_reg        <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                decode_slash_reg <= cfg_wdata;
            end
            in_valid_reg <= in_valid_next;
            if (advance)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    // end of string always leaves nothing held
    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        advance && in_last_reg |=> state_reg.held_count == HELD_NONE)
        else $error("held state survives end of string");

    // text end only on the last result of an item
    a_tlast_run: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> m_tuser)
        else $error("tlast without run end");

    // a run keeps going until its last result is taken
    a_run_holds: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !m_tuser |=> m_tvalid)
        else $error("result run broken off");

    // a new group never overwrites one still being delivered
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> out_free)
        else $error("result group overwritten");

endmodule

`default_nettype wire

// ----- rtl/upen_step.sv -----
`default_nettype none

module upen_step (
    input  wire logic                 decode_slash,
    input  wire logic [7:0]           in_byte,
    input  wire logic                 string_end,
    input  wire upen_pkg::upen_state_t state_cur,
    output upen_pkg::upen_state_t     state_next,
    output upen_pkg::upen_group_t     group
);
    import upen_pkg::*;

    logic [4:0] held_hex;
    logic [4:0] byte_hex;
    logic [7:0] value;
    logic       fresh;
    logic [1:0] n;
    logic [1:0] hc;
    logic [7:0] hd;
    logic [MAX_RESULTS-1:0][7:0] bytes;

    assign held_hex = hex_val(state_cur.held_digit);
    assign byte_hex = hex_val(in_byte);
    assign value    = {held_hex[3:0], byte_hex[3:0]};

    always_comb
    begin
        n     = 2'd0;
        bytes = '0;
        fresh = 1'b1;
        hc    = state_cur.held_count;
        hd    = state_cur.held_digit;
        case (state_cur.held_count)
            HELD_DIGIT:
            begin
                if (held_hex[4] && byte_hex[4])
                begin
                    if (is_unreserved(value) || (decode_slash && value == SLASH_CHAR))
                    begin
                        bytes[n] = value;
                        n = n + 2'd1;
                    end
                    else
                    begin
                        bytes[n] = PCT_CHAR;
                        n = n + 2'd1;
                        bytes[n] = hex_char(value[7:4]);
                        n = n + 2'd1;
                        bytes[n] = hex_char(value[3:0]);
                        n = n + 2'd1;
                    end
                    fresh = 1'b0;
                end
                else
                begin
                    bytes[n] = PCT_CHAR;
                    n = n + 2'd1;
                    bytes[n] = state_cur.held_digit;
                    n = n + 2'd1;
                end
                hc = HELD_NONE;
            end
            HELD_PCT:
            begin
                if (byte_hex[4])
                begin
                    hd    = in_byte;
                    hc    = HELD_DIGIT;
                    fresh = 1'b0;
                end
                else
                begin
                    bytes[n] = PCT_CHAR;
                    n = n + 2'd1;
                    hc = HELD_NONE;
                end
            end
            default:
            begin
                hc = HELD_NONE;
            end
        endcase

        if (fresh)
        begin
            if (in_byte == PCT_CHAR)
            begin
                hc = HELD_PCT;
            end
            else
            begin
                bytes[n] = in_byte;
                n = n + 2'd1;
            end
        end

        if (string_end)
        begin
            if (hc != HELD_NONE)
            begin
                bytes[n] = PCT_CHAR;
                n = n + 2'd1;
            end
            if (hc == HELD_DIGIT)
            begin
                bytes[n] = hd;
                n = n + 2'd1;
            end
            hc = HELD_NONE;
            hd = 8'd0;
        end

        state_next.held_count = hc;
        state_next.held_digit = hd;
        group.count           = n;
        group.text_end        = string_end;
        group.bytes           = bytes;
    end

endmodule

`default_nettype wire

// ----- rtl/upen_out.sv -----
`default_nettype none

module upen_out (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  load,
    input  wire upen_pkg::upen_group_t group_in,
    output logic                       free,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [7:0]                 m_tdata,
    output logic                       m_tuser,
    output logic                       m_tlast
);
    import upen_pkg::*;

    logic [1:0]                  count_reg, count_next;
    logic [1:0]                  idx_reg, idx_next;
    logic                        end_reg;
    logic [MAX_RESULTS-1:0][7:0] bytes_reg;
    logic                        last_byte;
    logic                        take;

    assign m_tvalid  = (count_reg != 2'd0);
    assign last_byte = (idx_reg == count_reg - 2'd1);
    assign take      = m_tvalid && m_tready;
    assign free      = !m_tvalid || (take && last_byte);
    assign m_tuser   = last_byte;
    assign m_tlast   = last_byte && end_reg;

    always_comb
    begin
        case (idx_reg)
            2'd0:    m_tdata = bytes_reg[0];
            2'd1:    m_tdata = bytes_reg[1];
            default: m_tdata = bytes_reg[2];
        endcase
    end

    always_comb
    begin
        count_next = count_reg;
        idx_next   = idx_reg;
        if (take)
        begin
            if (last_byte)
            begin
                count_next = 2'd0;
                idx_next   = 2'd0;
            end
            else
            begin
                idx_next = idx_reg + 2'd1;
            end
        end
        if (load)
        begin
            count_next = group_in.count;
            idx_next   = 2'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
            idx_reg   <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            end_reg   <= group_in.text_end;
            bytes_reg <= group_in.bytes;
        end
    end

endmodule

`default_nettype wire
